@@ sv/sbr_pkg.sv @@
// Shared types, constants and command codes for the spectrum bar renderer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sbr_pkg;

    // Bar table geometry
    localparam int MAX_BARS  = 128;
    localparam int BAR_PITCH = 4;
    localparam int BAR_W     = 3;
    localparam int BAR_AW    = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int MEM_AW    = BAR_AW + 1;
    localparam int MEM_DEPTH = 2 ** MEM_AW;

    // Opcodes
    localparam logic [1:0] OP_BAR  = 2'd0;
    localparam logic [1:0] OP_GRID = 2'd1;
    localparam logic [1:0] OP_PEAK = 2'd2;

    // Drawing command kinds
    localparam logic KIND_RECT = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_ZONE_SIZE     = 3'd0;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_BACK_COLOR    = 3'd3;
    localparam logic [2:0] CFG_LOW_COLOR     = 3'd4;
    localparam logic [2:0] CFG_MID_COLOR     = 3'd5;
    localparam logic [2:0] CFG_TOP_COLOR     = 3'd6;
    localparam logic [2:0] CFG_PEAK_COLOR    = 3'd7;

    // Configuration reset values
    localparam logic [6:0]  RST_ZONE_SIZE     = 7'd36;
    localparam logic [9:0]  RST_SCREEN_WIDTH  = 10'd320;
    localparam logic [9:0]  RST_SCREEN_HEIGHT = 10'd240;
    localparam logic [15:0] RST_BACK_COLOR    = 16'd0;
    localparam logic [15:0] RST_LOW_COLOR     = 16'd2016;
    localparam logic [15:0] RST_MID_COLOR     = 16'd65504;
    localparam logic [15:0] RST_TOP_COLOR     = 16'd63488;
    localparam logic [15:0] RST_PEAK_COLOR    = 16'd2047;

    // Emit selects: which drawing command the datapath builds this cycle
    localparam logic [2:0] EM_ERASE = 3'd0;
    localparam logic [2:0] EM_BAR   = 3'd1;
    localparam logic [2:0] EM_MID   = 3'd2;
    localparam logic [2:0] EM_HI    = 3'd3;
    localparam logic [2:0] EM_PKL   = 3'd4;
    localparam logic [2:0] EM_PKR   = 3'd5;
    localparam logic [2:0] EM_GL    = 3'd6;
    localparam logic [2:0] EM_GR    = 3'd7;

    typedef struct packed {
        logic [1:0] opcode;
        logic       channel;
        logic [6:0] slot;
        logic [7:0] level;
    } item_t;

    typedef struct packed {
        logic               cmd_kind;
        logic [9:0]         x_pos;
        logic signed [11:0] y_pos;
        logic [9:0]         span_width;
        logic [7:0]         span_height;
        logic [15:0]        color;
        logic               last;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       rd_ch;
        logic       load;
        logic       emit;
        logic [2:0] emit_sel;
        logic       last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] in_op;
        logic       in_ch;
        logic       bar_ok;
        logic       row_ok;
        logic       peak_nz;
        logic       shrink;
        logic       lo_full;
        logic       md_full;
    } stat_t;

endpackage

`default_nettype wire

@@ sv/spectrum_bar_peak_hold_renderer_core.sv @@
// Top level of the two-channel spectrum bar renderer with peak hold.
// Depends on sbr_pkg, sbr_ctrl and sbr_dp.
//
//   Channel  Handshake                   Word
//   -------  --------------------------  -----------------------------
//   item     start / busy                item_t: opcode channel slot level
//   result   result_valid (strobe)       result_t: one drawing command
//   config   cfg_valid / cfg_ready       cfg_index, cfg_data
//
// In a bar update the accept cycle reads the table, the next writes it back
// and emits the peak erase when there is one, then the states S_BAR, S_MID
// and S_HI emit the bar segments as far as the level reaches.
// A grid row or a peak-mark request emits two line words; the table has a single
// read port, so the two peak marks are read one after the other.
// Requests that give no result are dropped on accept and leave busy low.
// Reset returns state and config to their reset values and clears the table's valid bits at once.
// The receiver cannot stall; each result word is flagged by result_valid for one cycle.
`default_nettype none

module spectrum_bar_peak_hold_renderer_core
    import sbr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output result_t          result,
    output logic             result_valid,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    sbr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    sbr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

@@ sv/sbr_ctrl.sv @@
// Controller state machine of the spectrum bar renderer.
// Depends on sbr_pkg; drives the datapath by cmd_t, reads back stat_t.
`default_nettype none

module sbr_ctrl
    import sbr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_BAR  = 4'd2;
    localparam logic [3:0] S_MID  = 4'd3;
    localparam logic [3:0] S_HI   = 4'd4;
    localparam logic [3:0] S_PKL  = 4'd5;
    localparam logic [3:0] S_PKR  = 4'd6;
    localparam logic [3:0] S_GL   = 4'd7;
    localparam logic [3:0] S_GR   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign busy = (state_reg != S_IDLE);

    // Sequence the words of one item
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (stat.in_op)
                        OP_BAR:
                        begin
                            if (stat.bar_ok)
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_ch  = stat.in_ch;
                                state_next = S_LOAD;
                            end
                        end
                        OP_GRID:
                        begin
                            if (stat.row_ok)
                            begin
                                state_next = S_GL;
                            end
                        end
                        OP_PEAK:
                        begin
                            if (stat.bar_ok)
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_ch  = 1'b0;
                                state_next = S_PKL;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load     = 1'b1;
                cmd.emit     = stat.peak_nz;
                cmd.emit_sel = EM_ERASE;
                state_next   = S_BAR;
            end
            S_BAR:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_BAR;
                cmd.last     = stat.shrink || !stat.lo_full;
                state_next   = cmd.last ? S_IDLE : S_MID;
            end
            S_MID:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_MID;
                cmd.last     = !stat.md_full;
                state_next   = cmd.last ? S_IDLE : S_HI;
            end
            S_HI:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_HI;
                cmd.last     = 1'b1;
                state_next   = S_IDLE;
            end
            S_PKL:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_PKL;
                cmd.rd_en    = 1'b1;
                cmd.rd_ch    = 1'b1;
                state_next   = S_PKR;
            end
            S_PKR:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_PKR;
                cmd.last     = 1'b1;
                state_next   = S_IDLE;
            end
            S_GL:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_GL;
                state_next   = S_GR;
            end
            S_GR:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_GR;
                cmd.last     = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/sbr_dp.sv @@
// Datapath of the spectrum bar renderer: config registers, level/peak table,
// segment arithmetic and the result word register. Depends on sbr_pkg.
`default_nettype none

module sbr_dp
    import sbr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire item_t       item,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    output result_t          result,
    output logic             result_valid
);

    // Configuration registers
    logic [6:0]  zone_size_reg;
    logic [9:0]  screen_width_reg;
    logic [9:0]  screen_height_reg;
    logic [15:0] back_color_reg;
    logic [15:0] low_color_reg;
    logic [15:0] mid_color_reg;
    logic [15:0] top_color_reg;
    logic [15:0] peak_color_reg;

    // Item registers
    logic             ch_reg;
    logic [6:0]       slot_reg;
    logic [7:0]       level_reg;
    logic [11:0]      left_off_reg;
    logic [11:0]      right_off_reg;

    // Bar segment registers
    logic [7:0] now_reg;
    logic [7:0] lo_reg;
    logic [7:0] md_reg;
    logic [7:0] hi_reg;
    logic [7:0] lomd_reg;
    logic       shrink_reg;
    logic       lo_full_reg;
    logic       md_full_reg;

    // Table: {shown level, peak level} per channel and bar
    logic [15:0]          mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;
    logic [15:0]          rd_data_reg;
    logic                 rd_vld_reg;

    logic [7:0]        slot_ext;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_AW-1:0] wr_addr;
    logic [7:0]        now_rd;
    logic [7:0]        peak_rd;
    logic [7:0]        peak_next;
    logic [8:0]        full;
    logic [7:0]        two_zone;
    logic [7:0]        lo_next;
    logic [7:0]        md_next;
    logic [11:0]       left_off_next;
    logic [11:0]       right_off_next;
    logic [17:0]       x_full;
    logic [11:0]       peak12;
    logic [11:0]       row2;
    result_t           out_next;

    result_t out_reg;
    logic    strobe_reg;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_size_reg     <= RST_ZONE_SIZE;
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            back_color_reg    <= RST_BACK_COLOR;
            low_color_reg     <= RST_LOW_COLOR;
            mid_color_reg     <= RST_MID_COLOR;
            top_color_reg     <= RST_TOP_COLOR;
            peak_color_reg    <= RST_PEAK_COLOR;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ZONE_SIZE:     zone_size_reg     <= cfg_data[6:0];
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[9:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[9:0];
                CFG_BACK_COLOR:    back_color_reg    <= cfg_data;
                CFG_LOW_COLOR:     low_color_reg     <= cfg_data;
                CFG_MID_COLOR:     mid_color_reg     <= cfg_data;
                CFG_TOP_COLOR:     top_color_reg     <= cfg_data;
                CFG_PEAK_COLOR:    peak_color_reg    <= cfg_data;
                default:           zone_size_reg     <= zone_size_reg;
            endcase
        end
    end

    // Check the incoming item
    assign full     = {2'b00, zone_size_reg} + {1'b0, zone_size_reg, 1'b0};
    assign slot_ext = {1'b0, item.slot};

    always_comb
    begin
        stat         = '0;
        stat.in_op   = item.opcode;
        stat.in_ch   = item.channel;
        stat.bar_ok  = ({1'b0, slot_ext} < 9'(MAX_BARS));
        stat.row_ok  = (item.slot != 7'd0) && ({1'b0, item.slot} <= full[8:1]);
        stat.peak_nz = (peak_rd != 8'd0);
        stat.shrink  = shrink_reg;
        stat.lo_full = lo_full_reg;
        stat.md_full = md_full_reg;
    end

    // Bar area origins, fixed while busy
    assign left_off_next  = 12'(full) + 12'd1;
    assign right_off_next = 12'(screen_height_reg) - 12'(full) - 12'd1;

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg        <= item.channel;
            slot_reg      <= item.slot;
            level_reg     <= item.level;
            left_off_reg  <= left_off_next;
            right_off_reg <= right_off_next;
        end
    end

    // Table addressing
    always_comb
    begin
        if (cmd.capture)
        begin
            rd_addr = {cmd.rd_ch, slot_ext[BAR_AW-1:0]};
        end
        else
        begin
            rd_addr = {cmd.rd_ch, slot_reg[BAR_AW-1:0]};
        end
    end

    assign wr_addr = {ch_reg, slot_reg[BAR_AW-1:0]};

    // Read and write the table
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[wr_addr] <= {level_reg, peak_next};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Mark written entries; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign now_rd  = rd_vld_reg ? rd_data_reg[15:8] : 8'd0;
    assign peak_rd = rd_vld_reg ? rd_data_reg[7:0] : 8'd0;

    // Raise the peak, or drop it by one down to zero
    always_comb
    begin
        if (peak_rd < level_reg)
        begin
            peak_next = level_reg;
        end
        else if (peak_rd != 8'd0)
        begin
            peak_next = peak_rd - 8'd1;
        end
        else
        begin
            peak_next = 8'd0;
        end
    end

    // Split the new level into zone segments
    assign two_zone = {zone_size_reg, 1'b0};
    assign lo_next  = (level_reg > {1'b0, zone_size_reg}) ? {1'b0, zone_size_reg} : level_reg;
    assign md_next  = (level_reg > two_zone) ? {1'b0, zone_size_reg} : (level_reg - lo_next);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg     <= now_rd;
            lo_reg      <= lo_next;
            md_reg      <= md_next;
            hi_reg      <= level_reg - two_zone;
            lomd_reg    <= lo_next + md_next;
            shrink_reg  <= (now_rd >= level_reg);
            lo_full_reg <= (lo_next == {1'b0, zone_size_reg});
            md_full_reg <= (md_next == {1'b0, zone_size_reg});
        end
    end

    // Build the drawing command
    assign x_full = 18'(slot_reg) * 18'(BAR_PITCH);
    assign peak12 = {4'd0, peak_rd};
    assign row2   = {4'd0, slot_reg, 1'b0};

    always_comb
    begin
        out_next             = '0;
        out_next.cmd_kind    = KIND_RECT;
        out_next.x_pos       = x_full[9:0];
        out_next.span_width  = 10'(BAR_W);
        out_next.span_height = 8'd0;
        out_next.color       = back_color_reg;
        out_next.last        = cmd.last;
        case (cmd.emit_sel)
            EM_ERASE:
            begin
                out_next.cmd_kind = KIND_LINE;
                out_next.y_pos    = ch_reg ? (right_off_reg + peak12)
                                           : (left_off_reg + ~peak12);
            end
            EM_BAR:
            begin
                if (shrink_reg)
                begin
                    out_next.y_pos       = ch_reg ? (right_off_reg + {4'd0, level_reg})
                                                  : (left_off_reg - {4'd0, now_reg});
                    out_next.span_height = now_reg - level_reg;
                end
                else
                begin
                    out_next.y_pos       = ch_reg ? right_off_reg
                                                  : (left_off_reg - {4'd0, lo_reg});
                    out_next.span_height = lo_reg;
                    out_next.color       = low_color_reg;
                end
            end
            EM_MID:
            begin
                out_next.y_pos       = ch_reg ? (right_off_reg + {4'd0, lo_reg})
                                              : (left_off_reg - {4'd0, lomd_reg});
                out_next.span_height = md_reg;
                out_next.color       = mid_color_reg;
            end
            EM_HI:
            begin
                out_next.y_pos       = ch_reg ? (right_off_reg + {4'd0, lomd_reg})
                                              : (left_off_reg - {4'd0, level_reg});
                out_next.span_height = hi_reg;
                out_next.color       = top_color_reg;
            end
            EM_PKL:
            begin
                out_next.cmd_kind = KIND_LINE;
                out_next.y_pos    = left_off_reg + ~peak12;
                out_next.color    = peak_color_reg;
            end
            EM_PKR:
            begin
                out_next.cmd_kind = KIND_LINE;
                out_next.y_pos    = right_off_reg + peak12;
                out_next.color    = peak_color_reg;
            end
            EM_GL:
            begin
                out_next.cmd_kind   = KIND_LINE;
                out_next.x_pos      = 10'd0;
                out_next.span_width = screen_width_reg;
                out_next.y_pos      = left_off_reg - row2;
            end
            default:
            begin
                out_next.cmd_kind   = KIND_LINE;
                out_next.x_pos      = 10'd0;
                out_next.span_width = screen_width_reg;
                out_next.y_pos      = right_off_reg + row2 - 12'd1;
            end
        endcase
    end

    // Register the result word; it holds until the next emit
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
        end
    end

    assign result       = out_reg;
    assign result_valid = strobe_reg;

endmodule

`default_nettype wire
